/* src/bnalu_pkg.sv */
// bnalu_pkg: shared types and constants for the 256-bit limb arithmetic unit
// no dependencies; used by the channel interfaces and bignum_256_limb_alu_core
`default_nettype none

package bnalu_pkg;

    localparam int LIMB_W = 64;
    localparam int HALF_W = 32;
    localparam int OP_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_CMP = 3'd2,
        OP_MUL = 3'd3,
        OP_SQR = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MUL_PP,
        ST_MUL_ADD,
        ST_MUL_COL,
        ST_EMIT
    } state_t;

    localparam logic signed [1:0] SIGN_LT = 2'sb11;
    localparam logic signed [1:0] SIGN_EQ = 2'sb00;
    localparam logic signed [1:0] SIGN_GT = 2'sb01;

endpackage

`default_nettype wire

/* src/bnalu_if.sv */
// bnalu_if: valid/ready channel interfaces for operand items and result items
// depends on bnalu_pkg for limb and opcode widths
`default_nettype none

interface bnalu_in_if;
    import bnalu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [LIMB_W-1:0] x_limb;
    logic [LIMB_W-1:0] y_limb;

    modport source (output valid, output opcode, output x_limb, output y_limb, input ready);
    modport sink   (input valid, input opcode, input x_limb, input y_limb, output ready);
endinterface

interface bnalu_out_if;
    import bnalu_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIMB_W-1:0]  result_limb;
    logic               carry_flag;
    logic signed [1:0]  compare_sign;
    logic               x_is_zero;
    logic               last_result;

    modport source (
        output valid, output result_limb, output carry_flag, output compare_sign,
        output x_is_zero, output last_result, input ready
    );
    modport sink (
        input valid, input result_limb, input carry_flag, input compare_sign,
        input x_is_zero, input last_result, output ready
    );
endinterface

`default_nettype wire

/* src/bignum_256_limb_alu_core.sv */
// bignum_256_limb_alu_core: multi-limb unsigned add, subtract, compare, multiply, square
// depends on bnalu_pkg and the channel interfaces in bnalu_if.sv
//
// Usage:
//   req carries operand items (opcode, x_limb, y_limb), least significant limb first;
//   an operation is LIMB_COUNT items and the opcode is taken from the first of them.
//   rsp carries result items, least significant first, last_result on the final one.
//   add/sub give LIMB_COUNT limbs with the carry or borrow on the last; compare gives
//   one item; multiply and square give 2*LIMB_COUNT limbs; opcodes 5 to 7 give none.
//   While operands load, req accepts one item per cycle. Add, subtract and compare
//   are worked out as the limbs arrive, so the sequencer goes from ST_LOAD straight
//   to ST_EMIT once the last operand item is taken. Multiply and square run the
//   LIMB_COUNT^2 limb products through one shared 32x32 multiplier, four partial
//   products per limb product, each through ST_MUL_PP and ST_MUL_ADD, and a
//   ST_MUL_COL step then adds each limb product into its result column.
//   req is held low from the last operand item until the final result is loaded
//   into the output register; one result item leaves per cycle unless rsp stalls.
//   A stalled receiver holds the output register and the sequencer waits on it.
//   Reset empties the output register and starts a new operation at limb zero.
`default_nettype none

module bignum_256_limb_alu_core #(
    parameter int LIMB_COUNT = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bnalu_in_if.sink    req,
    bnalu_out_if.source rsp
);
    import bnalu_pkg::*;

    localparam int CNT_W = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
    localparam int ACC_W = CNT_W + 1;
    localparam int ACC_N = 2 * LIMB_COUNT;

    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(LIMB_COUNT - 1);
    localparam logic [ACC_W-1:0] EMIT_ADD  = ACC_W'(LIMB_COUNT - 1);
    localparam logic [ACC_W-1:0] EMIT_MUL  = ACC_W'(ACC_N - 1);

    // operand and result stores
    logic [LIMB_W-1:0] x_store [LIMB_COUNT];
    logic [LIMB_W-1:0] y_store [LIMB_COUNT];
    logic [LIMB_W-1:0] acc_mem [ACC_N];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  limb_cnt_reg, limb_cnt_next;
    logic [OP_W-1:0]   held_op_reg, held_op_next;
    logic              carry_reg, carry_next;
    logic signed [1:0] sign_reg, sign_next;
    logic              zero_reg, zero_next;
    logic [CNT_W-1:0]  mi_reg, mi_next;
    logic [CNT_W-1:0]  mj_reg, mj_next;
    logic [1:0]        mq_reg, mq_next;
    logic [ACC_W-1:0]  emit_idx_reg, emit_idx_next;
    logic              out_valid_reg, out_valid_next;

    logic [2*HALF_W-1:0] pp_reg, pp_next;
    logic [2*LIMB_W-1:0] prod_reg, prod_next;
    logic [LIMB_W-1:0]   col_carry_reg, col_carry_next;

    logic [LIMB_W-1:0] out_limb_reg;
    logic              out_carry_reg;
    logic signed [1:0] out_sign_reg;
    logic              out_zero_reg;
    logic              out_last_reg;

    // load-side datapath
    logic              req_fire;
    logic              first_limb;
    logic [OP_W-1:0]   eff_op;
    logic              cin;
    logic [LIMB_W:0]   addsub;
    logic signed [1:0] sign_prev;

    // multiply datapath
    logic [LIMB_W-1:0]   mul_a, mul_b;
    logic [HALF_W-1:0]   half_a, half_b;
    logic [2*LIMB_W-1:0] pp_shifted;
    logic [ACC_W-1:0]    col_idx;
    logic [LIMB_W-1:0]   col_rd;
    logic [LIMB_W-1:0]   col_cin;
    logic [LIMB_W+1:0]   col_sum;
    logic                col_we;
    logic                col_last_j;

    // result side
    logic              slot_free;
    logic              emit_load;
    logic [ACC_W-1:0]  emit_last_idx;
    logic              emit_is_last;
    logic              held_addsub;
    logic              held_cmp;

    assign req.ready   = (state_reg == ST_LOAD);
    assign req_fire    = req.valid && req.ready;
    assign first_limb  = (limb_cnt_reg == '0);
    assign eff_op      = first_limb ? req.opcode : held_op_reg;
    assign cin         = first_limb ? 1'b0 : carry_reg;
    assign sign_prev   = first_limb ? SIGN_EQ : sign_reg;

    always_comb
    begin
        if (eff_op == OP_SUB)
        begin
            addsub = {1'b0, req.x_limb} - {1'b0, req.y_limb} - {{LIMB_W{1'b0}}, cin};
        end
        else
        begin
            addsub = {1'b0, req.x_limb} + {1'b0, req.y_limb} + {{LIMB_W{1'b0}}, cin};
        end
    end

    assign mul_a  = x_store[mi_reg];
    assign mul_b  = y_store[mj_reg];
    assign half_a = mq_reg[1] ? mul_a[LIMB_W-1:HALF_W] : mul_a[HALF_W-1:0];
    assign half_b = mq_reg[0] ? mul_b[LIMB_W-1:HALF_W] : mul_b[HALF_W-1:0];

    always_comb
    begin
        case (mq_reg) inside
            2'd0:       pp_shifted = {{LIMB_W{1'b0}}, pp_reg};
            2'd1, 2'd2: pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default:    pp_shifted = {pp_reg, {LIMB_W{1'b0}}};
        endcase
    end

    // column step: acc[i+j] + lo + carry, carry out folds into hi
    assign col_idx    = {1'b0, mi_reg} + {1'b0, mj_reg};
    assign col_rd     = (mi_reg == '0) ? '0 : acc_mem[col_idx];
    assign col_cin    = (mj_reg == '0) ? '0 : col_carry_reg;
    assign col_sum    = {2'b00, col_rd} + {2'b00, prod_reg[LIMB_W-1:0]} + {2'b00, col_cin};
    assign col_last_j = (mj_reg == CNT_LAST);
    assign col_we     = (state_reg == ST_MUL_COL);

    assign held_addsub   = (held_op_reg == OP_ADD) || (held_op_reg == OP_SUB);
    assign held_cmp      = (held_op_reg == OP_CMP);
    assign emit_last_idx = held_cmp ? '0 : (held_addsub ? EMIT_ADD : EMIT_MUL);
    assign emit_is_last  = (emit_idx_reg == emit_last_idx);
    assign slot_free     = !out_valid_reg || rsp.ready;
    assign emit_load     = (state_reg == ST_EMIT) && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        limb_cnt_next  = limb_cnt_reg;
        held_op_next   = held_op_reg;
        carry_next     = carry_reg;
        sign_next      = sign_reg;
        zero_next      = zero_reg;
        mi_next        = mi_reg;
        mj_next        = mj_reg;
        mq_next        = mq_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        pp_next        = pp_reg;
        prod_next      = prod_reg;
        col_carry_next = col_carry_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (req_fire)
                begin
                    held_op_next  = eff_op;
                    carry_next    = addsub[LIMB_W];
                    zero_next     = (first_limb || zero_reg) && (req.x_limb == '0);
                    if (req.x_limb > req.y_limb)
                    begin
                        sign_next = SIGN_GT;
                    end
                    else if (req.x_limb < req.y_limb)
                    begin
                        sign_next = SIGN_LT;
                    end
                    else
                    begin
                        sign_next = sign_prev;
                    end
                    if (limb_cnt_reg == CNT_LAST)
                    begin
                        limb_cnt_next = '0;
                        emit_idx_next = '0;
                        mi_next       = '0;
                        mj_next       = '0;
                        mq_next       = '0;
                        case (eff_op) inside
                            OP_ADD, OP_SUB, OP_CMP: state_next = ST_EMIT;
                            OP_MUL, OP_SQR:         state_next = ST_MUL_PP;
                            default:                state_next = ST_LOAD;
                        endcase
                    end
                    else
                    begin
                        limb_cnt_next = limb_cnt_reg + 1'b1;
                    end
                end
            end
            ST_MUL_PP:
            begin
                pp_next    = half_a * half_b;
                state_next = ST_MUL_ADD;
            end
            ST_MUL_ADD:
            begin
                prod_next = ((mq_reg == 2'd0) ? '0 : prod_reg) + pp_shifted;
                mq_next   = mq_reg + 1'b1;
                if (mq_reg == 2'd3)
                begin
                    state_next = ST_MUL_COL;
                end
                else
                begin
                    state_next = ST_MUL_PP;
                end
            end
            ST_MUL_COL:
            begin
                col_carry_next = prod_reg[2*LIMB_W-1:LIMB_W] + {{(LIMB_W-2){1'b0}},
                                 col_sum[LIMB_W+1:LIMB_W]};
                state_next     = ST_MUL_PP;
                if (col_last_j)
                begin
                    mj_next = '0;
                    mi_next = mi_reg + 1'b1;
                    if (mi_reg == CNT_LAST)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    mj_next = mj_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    emit_idx_next  = emit_idx_reg + 1'b1;
                    if (emit_is_last)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            limb_cnt_reg  <= '0;
            held_op_reg   <= '0;
            carry_reg     <= 1'b0;
            sign_reg      <= SIGN_EQ;
            zero_reg      <= 1'b0;
            mi_reg        <= '0;
            mj_reg        <= '0;
            mq_reg        <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limb_cnt_reg  <= limb_cnt_next;
            held_op_reg   <= held_op_next;
            carry_reg     <= carry_next;
            sign_reg      <= sign_next;
            zero_reg      <= zero_next;
            mi_reg        <= mi_next;
            mj_reg        <= mj_next;
            mq_reg        <= mq_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and store registers, no reset
    always_ff @(posedge clk)
    begin
        pp_reg        <= pp_next;
        prod_reg      <= prod_next;
        col_carry_reg <= col_carry_next;
        if (req_fire)
        begin
            x_store[limb_cnt_reg] <= req.x_limb;
            y_store[limb_cnt_reg] <= (eff_op == OP_SQR) ? req.x_limb : req.y_limb;
            acc_mem[{1'b0, limb_cnt_reg}] <= addsub[LIMB_W-1:0];
        end
        if (col_we)
        begin
            acc_mem[col_idx] <= col_sum[LIMB_W-1:0];
            if (col_last_j)
            begin
                acc_mem[col_idx + 1'b1] <= col_carry_next;
            end
        end
        if (emit_load)
        begin
            out_limb_reg  <= held_cmp ? '0 : acc_mem[emit_idx_reg];
            out_carry_reg <= held_addsub && emit_is_last && carry_reg;
            out_sign_reg  <= held_cmp ? sign_reg : SIGN_EQ;
            out_zero_reg  <= held_cmp && zero_reg;
            out_last_reg  <= emit_is_last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_limb  = out_limb_reg;
    assign rsp.carry_flag   = out_carry_reg;
    assign rsp.compare_sign = out_sign_reg;
    assign rsp.x_is_zero    = out_zero_reg;
    assign rsp.last_result  = out_last_reg;

endmodule

`default_nettype wire
